/* rtl/rpse_pkg.sv */
// ----------------------------------------------------------------------------
// rpse_pkg
// Shared types and constants of the RAID-5 parity slice engine.
// ----------------------------------------------------------------------------
package rpse_pkg;

  localparam int unsigned MaxDrives   = 16;
  localparam int unsigned BlockWords  = 64;
  localparam int unsigned BlockBits   = 48;
  localparam int unsigned DriveBits   = 4;
  localparam int unsigned WordBits    = 6;
  localparam int unsigned CountBits   = 5;
  localparam int unsigned BufWords    = MaxDrives * BlockWords;
  localparam int unsigned BufAddrBits = DriveBits + WordBits;
  localparam int unsigned DataBits    = 64;

  localparam logic [2:0] OpFill       = 3'd0;
  localparam logic [2:0] OpRead       = 3'd1;
  localparam logic [2:0] OpWrite      = 3'd2;
  localparam logic [2:0] OpRebuild    = 3'd3;
  localparam logic [2:0] OpDrain      = 3'd4;
  localparam logic [2:0] OpInvalidate = 3'd5;

  typedef struct packed {
    logic [2:0]           operation;
    logic [BlockBits-1:0] logical_block;
    logic [BlockBits-1:0] slice_number;
    logic [DriveBits-1:0] drive_index;
    logic [WordBits-1:0]  word_index;
    logic [DataBits-1:0]  data_word;
    logic                 last_word;
  } in_t;

  typedef struct packed {
    logic [DataBits-1:0]  read_data;
    logic [BlockBits-1:0] mapped_slice;
    logic [DriveBits-1:0] data_drive;
    logic [DriveBits-1:0] parity_drive;
    logic                 slice_miss;
    logic                 buffer_dirty;
  } out_t;

  // one mapped request between front and back
  typedef struct packed {
    in_t                  item;
    logic [BlockBits-1:0] slice;
    logic [DriveBits-1:0] data_at;
    logic [DriveBits-1:0] par_drive;
  } rec_t;

endpackage

/* rtl/rpse_ram.sv */
// ----------------------------------------------------------------------------
// rpse_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rpse_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rpse_front.sv */
// ----------------------------------------------------------------------------
// rpse_front
// Accepts requests and maps the logical block: bit-serial division by n-1,
// with slice mod n tracked from the quotient bits as they appear.
// ----------------------------------------------------------------------------
module rpse_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rpse_pkg::CountBits-1:0] n_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rpse_pkg::in_t                 in_data_i,
  output logic                          push_o,
  output rpse_pkg::rec_t                push_data_o,
  input  logic                          full_i
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StPush
  } state_e;

  state_e                             state_q, state_d;
  rpse_pkg::in_t                      item_q, item_d;
  logic [rpse_pkg::BlockBits-1:0]     dvd_q, dvd_d;
  logic [rpse_pkg::BlockBits-1:0]     quo_q, quo_d;
  logic [rpse_pkg::CountBits-1:0]     rem_q, rem_d;
  logic [rpse_pkg::CountBits-1:0]     pmod_q, pmod_d;
  logic [5:0]                         cnt_q, cnt_d;

  logic [rpse_pkg::CountBits-1:0] dv;
  logic [rpse_pkg::CountBits:0]   trial, ptrial;
  logic                           qbit;
  logic [rpse_pkg::DriveBits-1:0] data_at;

  assign dv = n_i - rpse_pkg::CountBits'(1);

  always_comb begin
    trial  = {rem_q, dvd_q[rpse_pkg::BlockBits-1]};
    qbit   = (trial >= {1'b0, dv});
    ptrial = {pmod_q, qbit};
  end

  // data drive skips the parity drive
  always_comb begin
    data_at = rem_q[rpse_pkg::DriveBits-1:0];
    if (pmod_q <= rem_q) begin
      data_at = rem_q[rpse_pkg::DriveBits-1:0] + rpse_pkg::DriveBits'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    pmod_d  = pmod_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          dvd_d   = in_data_i.logical_block;
          quo_d   = '0;
          rem_d   = '0;
          pmod_d  = '0;
          cnt_d   = 6'(rpse_pkg::BlockBits);
          state_d = StDiv;
        end
      end
      StDiv: begin
        dvd_d = {dvd_q[rpse_pkg::BlockBits-2:0], 1'b0};
        quo_d = {quo_q[rpse_pkg::BlockBits-2:0], qbit};
        rem_d = qbit ? rpse_pkg::CountBits'(trial - {1'b0, dv})
                     : rpse_pkg::CountBits'(trial);
        pmod_d = (ptrial >= {1'b0, n_i}) ? rpse_pkg::CountBits'(ptrial - {1'b0, n_i})
                                         : rpse_pkg::CountBits'(ptrial);
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (!full_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      item_q  <= '0;
      dvd_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      pmod_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      item_q  <= item_d;
      dvd_q   <= dvd_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
      pmod_q  <= pmod_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o            = (state_q != StIdle);
  assign push_o                = (state_q == StPush) && !full_i;
  assign push_data_o.item      = item_q;
  assign push_data_o.slice     = quo_q;
  assign push_data_o.data_at   = data_at;
  assign push_data_o.par_drive = pmod_q[rpse_pkg::DriveBits-1:0];

endmodule

/* rtl/rpse_queue.sv */
// ----------------------------------------------------------------------------
// rpse_queue
// Two-entry queue of mapped requests between front and back.
// ----------------------------------------------------------------------------
module rpse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rpse_pkg::rec_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rpse_pkg::rec_t pop_data_o
);

  rpse_pkg::rec_t ent_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_data_i;
    end
  end

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = ent_q[rptr_q];

endmodule

/* rtl/rpse_back.sv */
// ----------------------------------------------------------------------------
// rpse_back
// Executes mapped requests on the slice buffer and holds the result register.
// ----------------------------------------------------------------------------
module rpse_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rpse_pkg::CountBits-1:0] n_i,
  input  logic                           empty_i,
  input  rpse_pkg::rec_t                 pop_data_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rpse_pkg::out_t                 out_data_o
);

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StRead,
    StWrD,
    StWrP,
    StWrData,
    StRebuild,
    StRebuildWr
  } state_e;

  state_e                           state_q, state_d;
  rpse_pkg::rec_t                   cur_q, cur_d;
  logic [rpse_pkg::BlockBits-1:0]   cached_q, cached_d;
  logic                             valid_q, valid_d;
  logic                             dirty_q, dirty_d;
  logic [rpse_pkg::DataBits-1:0]    old_q, old_d;
  logic [rpse_pkg::DataBits-1:0]    acc_q, acc_d;
  logic [rpse_pkg::CountBits-1:0]   j_q, j_d;
  logic                             pend_q, pend_d;
  logic                             ovalid_q, ovalid_d;
  rpse_pkg::out_t                   out_q, out_d;

  logic                               we;
  logic [rpse_pkg::BufAddrBits-1:0]   waddr, raddr;
  logic [rpse_pkg::DataBits-1:0]      wdata, rdata;
  logic                               d_ok, hit, done;
  logic [rpse_pkg::DataBits-1:0]      rd_val;
  logic                               miss;
  logic [rpse_pkg::DataBits-1:0]      acc_fin;

  rpse_ram #(
    .Width(rpse_pkg::DataBits),
    .Depth(rpse_pkg::BufWords)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign d_ok    = ({1'b0, cur_q.item.drive_index} < n_i);
  assign hit     = valid_q && (cached_q == cur_q.slice);
  assign acc_fin = acc_q ^ (pend_q ? rdata : '0);

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    cached_d = cached_q;
    valid_d  = valid_q;
    dirty_d  = dirty_q;
    old_d    = old_q;
    acc_d    = acc_q;
    j_d      = j_q;
    pend_d   = 1'b0;
    ovalid_d = ovalid_q && out_stall_i;
    out_d    = out_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = {cur_q.item.drive_index, cur_q.item.word_index};
    wdata    = cur_q.item.data_word;
    raddr    = {cur_q.data_at, cur_q.item.word_index};
    done     = 1'b0;
    rd_val   = '0;
    miss     = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!empty_i && !ovalid_q) begin
          pop_o   = 1'b1;
          cur_d   = pop_data_i;
          state_d = StExec;
        end
      end
      StExec: begin
        unique case (cur_q.item.operation) inside
          rpse_pkg::OpFill: begin
            if (d_ok) begin
              we      = 1'b1;
              valid_d = cur_q.item.last_word;
              dirty_d = 1'b0;
              if (cur_q.item.last_word) begin
                cached_d = cur_q.item.slice_number;
              end
            end
            done = 1'b1;
          end
          rpse_pkg::OpRead, rpse_pkg::OpWrite: begin
            if (!hit) begin
              miss = 1'b1;
              done = 1'b1;
            end else if (cur_q.item.operation == rpse_pkg::OpRead) begin
              state_d = StRead;
            end else begin
              state_d = StWrD;
            end
          end
          rpse_pkg::OpRebuild: begin
            acc_d = '0;
            j_d   = '0;
            if (d_ok) begin
              state_d = StRebuild;
            end else begin
              done = 1'b1;
            end
          end
          rpse_pkg::OpDrain: begin
            raddr = {cur_q.item.drive_index, cur_q.item.word_index};
            if (d_ok) begin
              state_d = StRead;
            end else begin
              done = 1'b1;
            end
          end
          rpse_pkg::OpInvalidate: begin
            valid_d = 1'b0;
            dirty_d = 1'b0;
            done    = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
      StRead: begin
        rd_val = rdata;
        if ((cur_q.item.operation == rpse_pkg::OpDrain) && cur_q.item.last_word) begin
          dirty_d = 1'b0;
        end
        done = 1'b1;
      end
      StWrD: begin
        // old data word arrives, fetch old parity
        old_d   = rdata;
        raddr   = {cur_q.par_drive, cur_q.item.word_index};
        state_d = StWrP;
      end
      StWrP: begin
        we      = 1'b1;
        waddr   = {cur_q.par_drive, cur_q.item.word_index};
        wdata   = rdata ^ old_q ^ cur_q.item.data_word;
        state_d = StWrData;
      end
      StWrData: begin
        we      = 1'b1;
        waddr   = {cur_q.data_at, cur_q.item.word_index};
        dirty_d = 1'b1;
        done    = 1'b1;
      end
      StRebuild: begin
        acc_d = acc_fin;
        raddr = {j_q[rpse_pkg::DriveBits-1:0], cur_q.item.word_index};
        if (j_q < n_i) begin
          pend_d = (j_q[rpse_pkg::DriveBits-1:0] != cur_q.item.drive_index);
          j_d    = j_q + rpse_pkg::CountBits'(1);
        end else begin
          state_d = StRebuildWr;
        end
      end
      StRebuildWr: begin
        we     = 1'b1;
        wdata  = acc_fin;
        rd_val = acc_fin;
        done   = 1'b1;
      end
      default: state_d = StIdle;
    endcase

    if (done) begin
      state_d               = StIdle;
      ovalid_d              = 1'b1;
      out_d.read_data       = rd_val;
      out_d.mapped_slice    = cur_q.slice;
      out_d.data_drive      = cur_q.data_at;
      out_d.parity_drive    = cur_q.par_drive;
      out_d.slice_miss      = miss;
      out_d.buffer_dirty    = dirty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cur_q    <= '0;
      cached_q <= '0;
      valid_q  <= 1'b0;
      dirty_q  <= 1'b0;
      old_q    <= '0;
      acc_q    <= '0;
      j_q      <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      cached_q <= cached_d;
      valid_q  <= valid_d;
      dirty_q  <= dirty_d;
      old_q    <= old_d;
      acc_q    <= acc_d;
      j_q      <= j_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
      out_q    <= out_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/raid5_parity_slice_engine_unit.sv */
// ----------------------------------------------------------------------------
// raid5_parity_slice_engine_unit
// One cached RAID-5 slice: mapping, fill, read, write, rebuild and drain.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_stall_o/in_data_i; one result leaves per
//   request on out_valid_o/out_stall_i/out_data_o. A transaction completes at
//   a clock edge with valid high and stall low.
//   The drive count register is written through cfg_valid_i/cfg_ready_o;
//   ready is always high. Write it only while the block is idle.
//   Mapping: the front maps the logical block with a bit-serial divider, one
//   quotient bit per cycle, then queues the transaction. In the back a write
//   reads old data and old parity, then writes parity and data; rebuild does
//   one buffer read per drive (single read port). The front takes no new
//   request until the current one is queued; the back overlaps with mapping
//   of the next transaction.
//   Reset clears the cached slice, valid and dirty flags and sets the drive
//   count to 3; buffer contents are undefined until filled.
//   When the receiver stalls the result register holds, the back stops after
//   it, the two-entry queue fills and finally in_stall_o stays high.
// ----------------------------------------------------------------------------
module raid5_parity_slice_engine_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rpse_pkg::CountBits-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rpse_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rpse_pkg::out_t                 out_data_o
);

  logic [rpse_pkg::CountBits-1:0] drive_count_q;
  logic [rpse_pkg::CountBits-1:0] n_eff;

  logic           push, full, pop, empty;
  rpse_pkg::rec_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_count_q <= rpse_pkg::CountBits'(3);
    end else if (cfg_valid_i) begin
      drive_count_q <= cfg_data_i;
    end
  end

  // effective drive count clamped to 3..MaxDrives
  always_comb begin
    n_eff = drive_count_q;
    if (drive_count_q < rpse_pkg::CountBits'(3)) begin
      n_eff = rpse_pkg::CountBits'(3);
    end else if (drive_count_q > rpse_pkg::CountBits'(rpse_pkg::MaxDrives)) begin
      n_eff = rpse_pkg::CountBits'(rpse_pkg::MaxDrives);
    end
  end

  rpse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n_eff),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  rpse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (pop_data)
  );

  rpse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n_eff),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RAID-5 parity slice engine: drives fill, read,
// write, rebuild, drain and invalidate traffic over several drive counts,
// predicts every result in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam int unsigned WatchLimit = 4000;
  localparam logic [47:0] BlockMax = 48'hFFFF_FFFF_FFFF;

  // Scoreboard: private copy of the slice state plus the queue of
  // predicted results, oldest first.
  class slice_scoreboard;
    logic [63:0]     words [rpse_pkg::BufWords];
    bit              written [rpse_pkg::BufWords];
    logic [47:0]     cached;
    bit              valid;
    bit              dirty;
    logic [4:0]      count_reg;
    rpse_pkg::out_t  pending [$];
    int              errors;
    int              op_seen [8];
    int              hits;
    int              misses;

    function new();
      cached = '0; valid = 0; dirty = 0; count_reg = 5'd3;
      errors = 0; hits = 0; misses = 0;
      foreach (written[i]) written[i] = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function int unsigned drives();
      int unsigned n;
      n = 32'(count_reg);
      if (n < 3) n = 3;
      if (n > rpse_pkg::MaxDrives) n = rpse_pkg::MaxDrives;
      return n;
    endfunction

    // slice / data drive / parity drive for one logical block
    function void map_block(input logic [47:0] blk, output logic [47:0] slice,
                            output int unsigned data_at, output int unsigned parity_drv);
      int unsigned n;
      n = drives();
      slice = blk / (n - 1);
      data_at = 32'(blk % (n - 1));
      parity_drv = 32'(slice % n);
      if (parity_drv <= data_at) data_at++;
    endfunction

    function int unsigned addr(int unsigned d, int unsigned w);
      return (d * rpse_pkg::BlockWords + w) % rpse_pkg::BufWords;
    endfunction

    function bit hit(logic [47:0] slice);
      return valid && cached == slice;
    endfunction

    // true when the item only touches buffer words that hold data
    function bit reads_defined(rpse_pkg::in_t it);
      logic [47:0] slice;
      int unsigned da, pa, n, w, d;
      bit ok;
      map_block(it.logical_block, slice, da, pa);
      n = drives();
      w = 32'(it.word_index);
      d = 32'(it.drive_index);
      ok = 1;
      case (it.operation)
        rpse_pkg::OpRead:  if (hit(slice)) ok = written[addr(da, w)];
        rpse_pkg::OpWrite: if (hit(slice))
                   ok = written[addr(da, w)] && written[addr(pa, w)];
        rpse_pkg::OpRebuild: if (d < n)
                     for (int j = 0; j < n; j++)
                       if (j != d && !written[addr(j, w)]) ok = 0;
        rpse_pkg::OpDrain: if (d < n) ok = written[addr(d, w)];
        default: ;
      endcase
      return ok;
    endfunction

    // accepted request: advance the state and queue the expected result
    function void note_request(rpse_pkg::in_t it);
      logic [47:0] slice;
      int unsigned da, pa, n, w, d;
      logic [63:0] acc;
      rpse_pkg::out_t r;
      map_block(it.logical_block, slice, da, pa);
      n = drives();
      w = 32'(it.word_index);
      d = 32'(it.drive_index);
      r = '0;
      op_seen[it.operation]++;
      case (it.operation)
        rpse_pkg::OpFill: if (d < n) begin
          words[addr(d, w)] = it.data_word;
          written[addr(d, w)] = 1;
          valid = 0;
          dirty = 0;
          if (it.last_word) begin
            cached = it.slice_number;
            valid = 1;
          end
        end
        rpse_pkg::OpRead, rpse_pkg::OpWrite: begin
          if (!hit(slice)) begin
            r.slice_miss = 1;
            misses++;
          end else begin
            hits++;
            if (it.operation == rpse_pkg::OpRead) begin
              r.read_data = words[addr(da, w)];
            end else begin
              words[addr(pa, w)] ^= it.data_word ^ words[addr(da, w)];
              words[addr(da, w)] = it.data_word;
              dirty = 1;
            end
          end
        end
        rpse_pkg::OpRebuild: if (d < n) begin
          acc = '0;
          for (int j = 0; j < n; j++)
            if (j != d) acc ^= words[addr(j, w)];
          words[addr(d, w)] = acc;
          written[addr(d, w)] = 1;
          r.read_data = acc;
        end
        rpse_pkg::OpDrain: if (d < n) begin
          r.read_data = words[addr(d, w)];
          if (it.last_word) dirty = 0;
        end
        rpse_pkg::OpInvalidate: begin
          valid = 0;
          dirty = 0;
        end
        default: ;
      endcase
      r.mapped_slice = slice;
      r.data_drive = da[3:0];
      r.parity_drive = pa[3:0];
      r.buffer_dirty = dirty;
      pending.push_back(r);
    endfunction

    function void check_result(rpse_pkg::out_t got);
      rpse_pkg::out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data exp %h got %h", $time, want.read_data, got.read_data);
        errors++;
      end
      if (got.mapped_slice !== want.mapped_slice) begin
        $display("%0t: mapped_slice exp %h got %h", $time, want.mapped_slice,
                 got.mapped_slice);
        errors++;
      end
      if (got.data_drive !== want.data_drive) begin
        $display("%0t: data_drive exp %0d got %0d", $time, want.data_drive, got.data_drive);
        errors++;
      end
      if (got.parity_drive !== want.parity_drive) begin
        $display("%0t: parity_drive exp %0d got %0d", $time, want.parity_drive,
                 got.parity_drive);
        errors++;
      end
      if (got.slice_miss !== want.slice_miss) begin
        $display("%0t: slice_miss exp %b got %b", $time, want.slice_miss, got.slice_miss);
        errors++;
      end
      if (got.buffer_dirty !== want.buffer_dirty) begin
        $display("%0t: buffer_dirty exp %b got %b", $time, want.buffer_dirty,
                 got.buffer_dirty);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [4:0]     cfg_data_i;
  logic           in_valid_i;
  logic           in_stall_o;
  rpse_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  rpse_pkg::out_t out_data_o;

  slice_scoreboard sb;
  bit          calm;      // no idling on either side while set
  int unsigned quiet;     // cycles without any transaction
  int          sent;

  raid5_parity_slice_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stall with a chance of 11 in 100, none while calm.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 11);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Watchdog on handshake progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic rpse_pkg::in_t make_req(logic [2:0] op, logic [47:0] blk,
                                             logic [47:0] sl, logic [3:0] drv,
                                             logic [5:0] w, logic [63:0] data,
                                             logic last);
    rpse_pkg::in_t it;
    it.operation = op;
    it.logical_block = blk;
    it.slice_number = sl;
    it.drive_index = drv;
    it.word_index = w;
    it.data_word = data;
    it.last_word = last;
    return it;
  endfunction

  // One transaction; valid stays high across back-to-back items. Requests that
  // would read never-written buffer words become a spare opcode instead.
  task automatic send_req(rpse_pkg::in_t it);
    if (!sb.reads_defined(it)) it.operation = OpSpare6;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(it);
    sent++;
    if (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
    end
  endtask

  task automatic drain_out();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_drive_count(logic [4:0] v);
    drain_out();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.count_reg = v;
  endtask

  // Fill every member drive at two words, last transaction marks the slice.
  task automatic fill_slice(logic [47:0] sl, logic [5:0] wa, logic [5:0] wb);
    int unsigned n;
    n = sb.drives();
    for (int d = 0; d < n; d++) begin
      send_req(make_req(rpse_pkg::OpFill, rand48(), sl, 4'(d), wa, rand64(), 1'b0));
      send_req(make_req(rpse_pkg::OpFill, rand48(), sl, 4'(d), wb, rand64(), d == n - 1));
    end
  endtask

  // Mostly well-formed traffic on the cached slice, some noise.
  task automatic random_phase(int items);
    int unsigned n, r;
    logic [47:0] sl, blk;
    logic [5:0]  wa, wb, w;
    logic [2:0]  op;
    n = sb.drives();
    sl = rand48() % (BlockMax / (n - 1));
    wa = 6'($urandom_range(63));
    wb = 6'($urandom_range(63));
    fill_slice(sl, wa, wb);
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      w = $urandom_range(1) ? wa : wb;
      blk = sl * (n - 1) + $urandom_range(n - 2);
      if (r < 28)      op = rpse_pkg::OpRead;
      else if (r < 55) op = rpse_pkg::OpWrite;
      else if (r < 67) op = rpse_pkg::OpRebuild;
      else if (r < 78) op = rpse_pkg::OpDrain;
      else if (r < 84) op = rpse_pkg::OpRead;
      else if (r < 88) op = rpse_pkg::OpFill;
      else if (r < 92) op = rpse_pkg::OpInvalidate;
      else if (r < 96) op = $urandom_range(1) ? OpSpare6 : OpSpare7;
      else             op = rpse_pkg::OpWrite;
      if (r >= 78 && r < 84 || r >= 96) blk = rand48();   // likely a miss
      send_req(make_req(op, blk, rand48(), 4'($urandom_range(15)),
                        (r >= 84 && r < 88) ? 6'($urandom_range(63)) : w,
                        rand64(), $urandom_range(3) == 0));
      if (!sb.valid) fill_slice(sl, wa, wb);
    end
    for (int d = 0; d < n; d++)
      send_req(make_req(rpse_pkg::OpDrain, blk, rand48(), 4'(d), wa, rand64(), d == n - 1));
  endtask

  initial begin
    logic [4:0] counts [6];
    sb = new();
    calm = 0;
    sent = 0;
    rst_ni = 0;
    cfg_valid_i = 0;
    cfg_data_i = '0;
    in_valid_i = 0;
    in_data_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset count, spare codes, misses with nothing cached,
    // out-of-range drives, extreme words and data, then hit paths.
    send_req(make_req(OpSpare6, BlockMax, BlockMax, 4'd15, 6'd63, '1, 1'b1));
    send_req(make_req(OpSpare7, '0, '0, '0, '0, '0, 1'b0));
    send_req(make_req(rpse_pkg::OpRead, BlockMax, '0, '0, 6'd63, '0, 1'b0));
    send_req(make_req(rpse_pkg::OpWrite, '0, '0, '0, '0, '1, 1'b0));
    send_req(make_req(rpse_pkg::OpInvalidate, BlockMax, '0, '0, '0, '0, 1'b0));
    send_req(make_req(rpse_pkg::OpDrain, '0, '0, 4'd15, '0, '0, 1'b1));
    send_req(make_req(rpse_pkg::OpRebuild, '0, '0, 4'd3, '0, '0, 1'b0));
    send_req(make_req(rpse_pkg::OpFill, '0, '0, 4'd3, '0, '1, 1'b1));
    for (int d = 0; d < 3; d++) begin
      send_req(make_req(rpse_pkg::OpFill, '0, '0, 4'(d), 6'd0, d == 0 ? '0 : '1, 1'b0));
      send_req(make_req(rpse_pkg::OpFill, '0, '0, 4'(d), 6'd63, rand64(), d == 2));
    end
    send_req(make_req(rpse_pkg::OpRead, 48'd1, '0, '0, 6'd0, '0, 1'b0));
    send_req(make_req(rpse_pkg::OpWrite, 48'd0, '0, '0, 6'd63, '1, 1'b0));
    send_req(make_req(rpse_pkg::OpRebuild, 48'd2, '0, 4'd1, 6'd63, '0, 1'b0));
    send_req(make_req(rpse_pkg::OpRead, 48'd2, '0, '0, 6'd0, '0, 1'b0));
    send_req(make_req(rpse_pkg::OpDrain, 48'd0, '0, 4'd2, 6'd63, '0, 1'b1));
    send_req(make_req(rpse_pkg::OpInvalidate, '0, '0, '0, '0, '0, 1'b0));

    // Random phases over several drive counts, clamp values included.
    counts = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd7, 5'($urandom_range(4, 15))};
    foreach (counts[p]) begin
      set_drive_count(counts[p]);
      calm = (p == 2);
      random_phase(20);
      if (p == 3) drain_out();     // sender holds off until all results are in
    end
    calm = 0;

    drain_out();
    repeat (60) @(posedge clk_i);
    $display("%0d requests: %0d fill %0d read %0d write %0d rebuild %0d drain %0d inval",
             sent, sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3],
             sb.op_seen[4], sb.op_seen[5]);
    $display("slice hits %0d, misses %0d, drive counts swept incl. clamp", sb.hits,
             sb.misses);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* raid5_parity_slice_engine_unit.f */
rtl/rpse_pkg.sv
rtl/rpse_ram.sv
rtl/rpse_front.sv
rtl/rpse_queue.sv
rtl/rpse_back.sv
rtl/raid5_parity_slice_engine_unit.sv
tb/sv/testbench.sv
